@@ hdl/transform_to_position_quaternion_defines.svh @@
`ifndef TRANSFORM_TO_POSITION_QUATERNION_DEFINES_SVH
`define TRANSFORM_TO_POSITION_QUATERNION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TPQ_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TPQ_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/tpq_pkg.sv @@
`default_nettype none
package tpq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int ROT_W     = 18;
	localparam int POS_W     = 32;
	localparam int A_W       = ROT_W + 3;
	localparam int X_W       = A_W - 1 + FRAC_BITS;
	localparam int RT_W      = (X_W + 1) / 2;
	localparam int D_W       = ROT_W + 1;
	localparam int N_W       = D_W + FRAC_BITS;
	localparam int DEN_W     = RT_W + 1;
	localparam int Q_W       = ROT_W - 1;
	localparam int R_W       = DEN_W + Q_W;
	localparam int SQ_LAT    = RT_W;
	localparam int DV_LAT    = Q_W + 1;
	localparam int LAT       = 1 + SQ_LAT + DV_LAT + 1;

	localparam logic signed [ROT_W-1:0] ONE_Q = ROT_W'(longint'(1) << FRAC_BITS);

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [D_W-1:0]   diff_t;
	typedef logic [RT_W-1:0]         root_t;

	typedef enum logic [1:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

	typedef struct packed {
		diff_t d0;
		diff_t d1;
		diff_t d2;
	} diff3_t;

	typedef struct packed {
		pos_t px;
		pos_t py;
		pos_t pz;
	} pos3_t;
endpackage
`default_nettype wire

@@ hdl/tpq_sel.sv @@
`default_nettype none
module tpq_sel
	import tpq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              adv,
	input  wire rot_t              m00,
	input  wire rot_t              m01,
	input  wire rot_t              m02,
	input  wire rot_t              m10,
	input  wire rot_t              m11,
	input  wire rot_t              m12,
	input  wire rot_t              m20,
	input  wire rot_t              m21,
	input  wire rot_t              m22,
	output logic [A_W-2:0]         a_s1,
	output branch_t                br_s1,
	output diff3_t                 d_s1
);
	localparam logic signed [A_W-1:0] ONE_A = A_W'(longint'(1) << FRAC_BITS);

	logic signed [A_W-1:0] e00, e11, e22, tr, a_raw;
	branch_t               br;
	diff3_t                d;
	diff_t                 d_21m12, d_02m20, d_10m01, d_01p10, d_02p20, d_12p21;

	always_comb begin
		e00 = A_W'(m00);
		e11 = A_W'(m11);
		e22 = A_W'(m22);
		tr  = e00 + e11 + e22;
		d_21m12 = D_W'(m21) - D_W'(m12);
		d_02m20 = D_W'(m02) - D_W'(m20);
		d_10m01 = D_W'(m10) - D_W'(m01);
		d_01p10 = D_W'(m01) + D_W'(m10);
		d_02p20 = D_W'(m02) + D_W'(m20);
		d_12p21 = D_W'(m12) + D_W'(m21);
		if (tr > 0) begin
			br = BR_W;
		end else if (m00 > m11 && m00 > m22) begin
			br = BR_X;
		end else if (m11 > m22) begin
			br = BR_Y;
		end else begin
			br = BR_Z;
		end
		case (br)
			BR_W: begin
				a_raw = tr + ONE_A;
				d = '{d0: d_21m12, d1: d_02m20, d2: d_10m01};
			end
			BR_X: begin
				a_raw = ONE_A + e00 - e11 - e22;
				d = '{d0: d_21m12, d1: d_01p10, d2: d_02p20};
			end
			BR_Y: begin
				a_raw = ONE_A + e11 - e00 - e22;
				d = '{d0: d_02m20, d1: d_01p10, d2: d_12p21};
			end
			default: begin
				a_raw = ONE_A + e22 - e00 - e11;
				d = '{d0: d_10m01, d1: d_02p20, d2: d_12p21};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= (a_raw <= 0) ? (A_W-1)'(1) : a_raw[A_W-2:0];
			br_s1 <= br;
			d_s1  <= d;
		end
	end
endmodule
`default_nettype wire

@@ hdl/tpq_sqrt.sv @@
`default_nettype none
module tpq_sqrt
	import tpq_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          adv,
	input  wire logic [A_W-2:0] a,
	output root_t              root
);
	root_t      root_s [0:SQ_LAT-1];
	logic [X_W:0] rem_s [0:SQ_LAT-1];

	for (genvar g = 0; g < SQ_LAT; g++) begin : g_bit
		localparam int B = RT_W - 1 - g;
		root_t        r_cur;
		logic [X_W:0] x_cur, trial;
		logic         take;

		if (g == 0) begin : g_first
			assign r_cur = '0;
			assign x_cur = (X_W+1)'({a, {FRAC_BITS{1'b0}}});
		end else begin : g_next
			assign r_cur = root_s[g-1];
			assign x_cur = rem_s[g-1];
		end

		assign trial = ((X_W+1)'(r_cur) << (B + 1)) | ((X_W+1)'(1) << (2 * B));
		assign take  = x_cur >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[g] <= take ? (r_cur | (RT_W'(1) << B)) : r_cur;
				rem_s[g]  <= take ? (x_cur - trial) : x_cur;
			end
		end
	end

	assign root = root_s[SQ_LAT-1];
endmodule
`default_nettype wire

@@ hdl/tpq_div.sv @@
`default_nettype none
module tpq_div
	import tpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic adv,
	input  wire diff_t d,
	input  wire root_t root,
	output rot_t      q
);
	logic [R_W-1:0]   rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic             neg_s [0:Q_W];
	logic             ovf_s [0:Q_W];

	logic             d_neg;
	logic [D_W-1:0]   mag;
	logic [N_W-1:0]   num;
	logic [DEN_W-1:0] den;

	always_comb begin
		d_neg = d[D_W-1];
		mag   = d_neg ? D_W'(-d) : D_W'(d);
		num   = {mag, {FRAC_BITS{1'b0}}};
		den   = {root, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= R_W'(num);
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= d_neg;
			ovf_s[0] <= R_W'(num) >= (R_W'(den) << Q_W);
		end
	end

	for (genvar g = 0; g < Q_W; g++) begin : g_bit
		localparam int B = Q_W - 1 - g;
		logic [R_W-1:0] trial;
		logic           take;

		assign trial = R_W'(den_s[g]) << B;
		assign take  = rem_s[g] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= take ? (rem_s[g] - trial) : rem_s[g];
				q_s[g+1]   <= take ? (q_s[g] | (Q_W'(1) << B)) : q_s[g];
				den_s[g+1] <= den_s[g];
				neg_s[g+1] <= neg_s[g];
				ovf_s[g+1] <= ovf_s[g];
			end
		end
	end

	logic [ROT_W-1:0] mag_sat;

	always_comb begin
		if (ovf_s[Q_W] || ROT_W'(q_s[Q_W]) > ONE_Q) begin
			mag_sat = ONE_Q;
		end else begin
			mag_sat = ROT_W'(q_s[Q_W]);
		end
		q = neg_s[Q_W] ? -rot_t'(mag_sat) : rot_t'(mag_sat);
	end
endmodule
`default_nettype wire

@@ hdl/transform_to_position_quaternion.sv @@
// Transform to position and quaternion. Each item carries a Q16.16 translation and a 3x3
// rotation matrix in signed Q16; each result gives the translation unchanged and the rotation
// as a saturated Q16 quaternion (x, y, z, w) from the four-branch method with one square
// root and three divisions by twice the root. The block takes one item every cycle while
// in_stall is low and passes it through a branch-selection stage, an 18-bit square root at
// one root bit per stage, a division setup stage, then 17 stages at one quotient bit
// each, and one output register. When out_stall holds a waiting result, the whole
// pipeline holds and in_stall rises in the same cycle; an empty output never stalls input.
`default_nettype none
`include "transform_to_position_quaternion_defines.svh"
module transform_to_position_quaternion
	import tpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire pos_t trans_x,
	input  wire pos_t trans_y,
	input  wire pos_t trans_z,
	input  wire rot_t rot_00,
	input  wire rot_t rot_01,
	input  wire rot_t rot_02,
	input  wire rot_t rot_10,
	input  wire rot_t rot_11,
	input  wire rot_t rot_12,
	input  wire rot_t rot_20,
	input  wire rot_t rot_21,
	input  wire rot_t rot_22,
	output logic      out_valid,
	input  wire logic out_stall,
	output pos_t      pos_x,
	output pos_t      pos_y,
	output pos_t      pos_z,
	output rot_t      quat_x,
	output rot_t      quat_y,
	output rot_t      quat_z,
	output rot_t      quat_w
);
	logic           adv;
	logic [LAT-1:0] vld_q;

	logic [A_W-2:0] a_s1;
	branch_t        br_s1;
	diff3_t         d_s1;
	root_t          root;
	rot_t           q0, q1, q2;

	pos3_t   pos_line_q [0:LAT-1];
	diff3_t  d_line_q   [0:SQ_LAT-1];
	branch_t br_line_q  [0:SQ_LAT+DV_LAT-1];
	root_t   r_line_q   [0:DV_LAT-1];

	rot_t qx_q, qy_q, qz_q, qw_q;
	rot_t main_c;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	tpq_sel u_sel (
		.clk   (clk),
		.adv   (adv),
		.m00   (rot_00),
		.m01   (rot_01),
		.m02   (rot_02),
		.m10   (rot_10),
		.m11   (rot_11),
		.m12   (rot_12),
		.m20   (rot_20),
		.m21   (rot_21),
		.m22   (rot_22),
		.a_s1  (a_s1),
		.br_s1 (br_s1),
		.d_s1  (d_s1)
	);

	tpq_sqrt u_sqrt (
		.clk  (clk),
		.adv  (adv),
		.a    (a_s1),
		.root (root)
	);

	tpq_div u_div0 (.clk(clk), .adv(adv), .d(d_line_q[SQ_LAT-1].d0), .root(root), .q(q0));
	tpq_div u_div1 (.clk(clk), .adv(adv), .d(d_line_q[SQ_LAT-1].d1), .root(root), .q(q1));
	tpq_div u_div2 (.clk(clk), .adv(adv), .d(d_line_q[SQ_LAT-1].d2), .root(root), .q(q2));

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_line_q[0] <= '{px: trans_x, py: trans_y, pz: trans_z};
			for (int k = 1; k < LAT; k++) begin
				pos_line_q[k] <= pos_line_q[k-1];
			end
			d_line_q[0] <= d_s1;
			for (int k = 1; k < SQ_LAT; k++) begin
				d_line_q[k] <= d_line_q[k-1];
			end
			br_line_q[0] <= br_s1;
			for (int k = 1; k < SQ_LAT + DV_LAT; k++) begin
				br_line_q[k] <= br_line_q[k-1];
			end
			r_line_q[0] <= root;
			for (int k = 1; k < DV_LAT; k++) begin
				r_line_q[k] <= r_line_q[k-1];
			end
		end
	end

	always_comb begin
		if (ROT_W'(r_line_q[DV_LAT-1] >> 1) > ONE_Q) begin
			main_c = ONE_Q;
		end else begin
			main_c = rot_t'(ROT_W'(r_line_q[DV_LAT-1] >> 1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (br_line_q[SQ_LAT+DV_LAT-1])
				BR_W: begin
					qw_q <= main_c; qx_q <= q0; qy_q <= q1; qz_q <= q2;
				end
				BR_X: begin
					qx_q <= main_c; qw_q <= q0; qy_q <= q1; qz_q <= q2;
				end
				BR_Y: begin
					qy_q <= main_c; qw_q <= q0; qx_q <= q1; qz_q <= q2;
				end
				default: begin
					qz_q <= main_c; qw_q <= q0; qx_q <= q1; qy_q <= q2;
				end
			endcase
		end
	end

	assign pos_x  = pos_line_q[LAT-1].px;
	assign pos_y  = pos_line_q[LAT-1].py;
	assign pos_z  = pos_line_q[LAT-1].pz;
	assign quat_x = qx_q;
	assign quat_y = qy_q;
	assign quat_z = qz_q;
	assign quat_w = qw_q;

	`TPQ_ASSERT_IMP(a_root_min, vld_q[SQ_LAT], root >= (RT_W'(1) << (FRAC_BITS / 2)), "root below clamp floor")
	`TPQ_ASSERT_IMP(a_main_pos, out_valid, (quat_w > 0 || quat_x > 0 || quat_y > 0 || quat_z > 0), "no positive branch component")
	`TPQ_ASSERT_NXT(a_hold, !adv, $stable(vld_q), "pipeline moved while held")
endmodule
`default_nettype wire

@@ tb/transform_to_position_quaternion_test.sv @@
`default_nettype none
module transform_to_position_quaternion_test
	import tpq_pkg::*;
;

	localparam int ITEMS     = 1150;
	localparam int LIMIT     = 400000;
	localparam int DRAIN     = LAT + 20;
	localparam longint ONE   = longint'(1) << FRAC_BITS;

	typedef struct {
		pos_t tx, ty, tz;
		rot_t m[9];
	} xform_t;

	typedef struct {
		pos_t px, py, pz;
		rot_t qx, qy, qz, qw;
	} pose_t;

	typedef struct {
		xform_t t;
		bit     known;
		pose_t  p;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic in_stall, out_valid;
	pos_t trans_x = '0, trans_y = '0, trans_z = '0;
	rot_t rm[9] = '{default: '0};
	pos_t pos_x, pos_y, pos_z;
	rot_t quat_x, quat_y, quat_z, quat_w;

	pose_t expected_poses[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	bit done = 0;

	transform_to_position_quaternion DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
		.rot_00(rm[0]), .rot_01(rm[1]), .rot_02(rm[2]),
		.rot_10(rm[3]), .rot_11(rm[4]), .rot_12(rm[5]),
		.rot_20(rm[6]), .rot_21(rm[7]), .rot_22(rm[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic longint int_root(longint a);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > a) b = b >>> 2;
		while (b != 0) begin
			if (a >= res + b) begin
				a = a - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic longint scaled_quot(longint d, longint r);
		return (d * ONE) / (2 * r);
	endfunction

	function automatic rot_t clamp_unit(longint v);
		if (v > ONE) return rot_t'(ONE);
		if (v < -ONE) return rot_t'(-ONE);
		return rot_t'(v);
	endfunction

	function automatic pose_t pose_of(xform_t t);
		longint m[9];
		longint tr, a, r, qx, qy, qz, qw;
		pose_t p;
		for (int i = 0; i < 9; i++) m[i] = longint'(t.m[i]);
		tr = m[0] + m[4] + m[8];
		if (tr > 0) begin
			a = tr + ONE;
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			a = ONE + m[0] - m[4] - m[8];
		end else if (m[4] > m[8]) begin
			a = ONE + m[4] - m[0] - m[8];
		end else begin
			a = ONE + m[8] - m[0] - m[4];
		end
		if (a < 1) a = 1;
		r = int_root(a * ONE);
		if (tr > 0) begin
			qw = r / 2;
			qx = scaled_quot(m[7] - m[5], r);
			qy = scaled_quot(m[2] - m[6], r);
			qz = scaled_quot(m[3] - m[1], r);
		end else if (m[0] > m[4] && m[0] > m[8]) begin
			qx = r / 2;
			qw = scaled_quot(m[7] - m[5], r);
			qy = scaled_quot(m[1] + m[3], r);
			qz = scaled_quot(m[2] + m[6], r);
		end else if (m[4] > m[8]) begin
			qy = r / 2;
			qw = scaled_quot(m[2] - m[6], r);
			qx = scaled_quot(m[1] + m[3], r);
			qz = scaled_quot(m[5] + m[7], r);
		end else begin
			qz = r / 2;
			qw = scaled_quot(m[3] - m[1], r);
			qx = scaled_quot(m[2] + m[6], r);
			qy = scaled_quot(m[5] + m[7], r);
		end
		p.px = t.tx;
		p.py = t.ty;
		p.pz = t.tz;
		p.qx = clamp_unit(qx);
		p.qy = clamp_unit(qy);
		p.qz = clamp_unit(qz);
		p.qw = clamp_unit(qw);
		return p;
	endfunction

	function automatic rot_t any_entry();
		case ($urandom_range(0, 5))
			0: return rot_t'(ONE);
			1: return rot_t'(-ONE);
			2: return rot_t'($urandom());
			default: return rot_t'(longint'($urandom_range(0, 2 * ONE)) - ONE);
		endcase
	endfunction

	function automatic pos_t any_pos();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			default: return pos_t'($urandom());
		endcase
	endfunction

	// rotation from a random unit quaternion, with a little noise on the entries
	function automatic xform_t random_rotation();
		xform_t t;
		real w, x, y, z, n, v[9];
		w = $urandom_range(0, 2000) - 1000.0;
		x = $urandom_range(0, 2000) - 1000.0;
		y = $urandom_range(0, 2000) - 1000.0;
		z = $urandom_range(0, 2000) - 1000.0;
		n = $sqrt(w * w + x * x + y * y + z * z) + 1.0;
		w /= n; x /= n; y /= n; z /= n;
		v[0] = 1 - 2 * (y * y + z * z); v[1] = 2 * (x * y - z * w); v[2] = 2 * (x * z + y * w);
		v[3] = 2 * (x * y + z * w); v[4] = 1 - 2 * (x * x + z * z); v[5] = 2 * (y * z - x * w);
		v[6] = 2 * (x * z - y * w); v[7] = 2 * (y * z + x * w); v[8] = 1 - 2 * (x * x + y * y);
		for (int i = 0; i < 9; i++) begin
			longint q;
			q = longint'(v[i] * ONE) + $urandom_range(0, 6) - 3;
			if (q > ONE) q = ONE;
			if (q < -ONE) q = -ONE;
			t.m[i] = rot_t'(q);
		end
		t.tx = any_pos();
		t.ty = any_pos();
		t.tz = any_pos();
		return t;
	endfunction

	function automatic xform_t diag(longint a, longint b, longint c);
		xform_t t;
		t.tx = 0; t.ty = 0; t.tz = 0;
		t.m = '{default: '0};
		t.m[0] = rot_t'(a); t.m[4] = rot_t'(b); t.m[8] = rot_t'(c);
		return t;
	endfunction

	task automatic send(xform_t t, pose_t p);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		trans_x <= t.tx; trans_y <= t.ty; trans_z <= t.tz;
		for (int i = 0; i < 9; i++) rm[i] <= t.m[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_poses.push_back(p);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					$error("unexpected result");
					errors++;
				end else begin
					pose_t e;
					e = expected_poses.pop_front();
					if (pos_x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, pos_x); errors++; end
					if (pos_y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, pos_y); errors++; end
					if (pos_z !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, pos_z); errors++; end
					if (quat_x !== e.qx) begin $error("quat_x exp %0d got %0d", e.qx, quat_x); errors++; end
					if (quat_y !== e.qy) begin $error("quat_y exp %0d got %0d", e.qy, quat_y); errors++; end
					if (quat_z !== e.qz) begin $error("quat_z exp %0d got %0d", e.qz, quat_z); errors++; end
					if (quat_w !== e.qw) begin $error("quat_w exp %0d got %0d", e.qw, quat_w); errors++; end
				end
			end
		end
	end

	int stall_run = 0;
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_run <= $urandom_range(0, 8);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT && !done) begin
			$display("transform_to_position_quaternion regression: fail");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		xform_t t;
		pose_t p;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity: w branch, exact
		rw.t = diag(ONE, ONE, ONE);
		rw.t.tx = 32'sh7fffffff; rw.t.ty = 32'sh80000000; rw.t.tz = -1;
		rw.known = 1;
		rw.p = '{32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, rot_t'(ONE)};
		rows.push_back(rw);
		// half turns about x, y, z
		rw.t = diag(ONE, -ONE, -ONE); rw.p = '{0, 0, 0, rot_t'(ONE), 0, 0, 0};
		rows.push_back(rw);
		rw.t = diag(-ONE, ONE, -ONE); rw.p = '{0, 0, 0, 0, rot_t'(ONE), 0, 0};
		rows.push_back(rw);
		rw.t = diag(-ONE, -ONE, ONE); rw.p = '{0, 0, 0, 0, 0, rot_t'(ONE), 0};
		rows.push_back(rw);
		// trace not positive and ties on the diagonal
		rw.known = 0;
		rows.push_back('{diag(-ONE, -ONE, -ONE), 0, p});
		rows.push_back('{diag(0, 0, 0), 0, p});
		rows.push_back('{diag(ONE, ONE, 0), 0, p});
		rows.push_back('{diag(0, ONE, ONE), 0, p});
		rows.push_back('{diag(-ONE, ONE, ONE), 0, p});
		rows.push_back('{diag(ONE, ONE, -ONE), 0, p});
		// entries out of range, full 18-bit extremes
		rows.push_back('{diag(131071, -131072, 131071), 0, p});
		rows.push_back('{diag(-131072, -131072, -131072), 0, p});
		t = diag(-ONE, -ONE, -ONE);
		for (int i = 0; i < 9; i++)
			if (i % 4 != 0) t.m[i] = (i & 1) ? rot_t'(131071) : rot_t'(-131072);
		rows.push_back('{t, 0, p});
		t = diag(1, 0, 0);
		for (int i = 0; i < 9; i++)
			if (i % 4 != 0) t.m[i] = (i & 1) ? rot_t'(-131072) : rot_t'(131071);
		rows.push_back('{t, 0, p});
		for (int k = 0; k < 6; k++) rows.push_back('{random_rotation(), 0, p});

		foreach (rows[i]) begin
			p = rows[i].known ? rows[i].p : pose_of(rows[i].t);
			send(rows[i].t, p);
		end

		for (int n = 0; n < ITEMS; n++) begin
			if (n == 300) begin
				in_valid <= 0;
				while (expected_poses.size() != 0) @(posedge clk);
			end
			if (n == ITEMS - 150) calm = 1;
			if ($urandom_range(0, 9) < 8) begin
				t = random_rotation();
			end else begin
				t.tx = any_pos(); t.ty = any_pos(); t.tz = any_pos();
				for (int i = 0; i < 9; i++) t.m[i] = any_entry();
			end
			send(t, pose_of(t));
		end
		in_valid <= 0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		done = 1;
		if (errors == 0 && expected_poses.size() == 0)
			$display("transform_to_position_quaternion regression: pass");
		else
			$display("transform_to_position_quaternion regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
